@@ sv/tdcu_pkg.sv @@
// tdcu_pkg: shared types, codes and helpers of the TDC event word unpacker.
// No dependencies; used by tdc_event_word_unpacker.

package tdcu_pkg;

    // Channel store geometry
    localparam int NUM_CHANNELS = 32;
    localparam int CH_W         = $clog2(NUM_CHANNELS);

    // Field widths
    localparam int WORD_W  = 32;
    localparam int TYPE_W  = 5;
    localparam int VALUE_W = 21;
    localparam int TAG_W   = 27;
    localparam int SLOT_W  = 5;
    localparam int CNT_W   = 8;
    localparam int KIND_W  = 3;
    localparam int ERR_W   = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Word type codes (bits 31..27)
    localparam logic [TYPE_W-1:0] TYPE_DATA = 5'd0;
    localparam logic [TYPE_W-1:0] TYPE_THDR = 5'd1;
    localparam logic [TYPE_W-1:0] TYPE_TTRL = 5'd3;
    localparam logic [TYPE_W-1:0] TYPE_TERR = 5'd4;
    localparam logic [TYPE_W-1:0] TYPE_GHDR = 5'd8;
    localparam logic [TYPE_W-1:0] TYPE_GTRL = 5'd16;
    localparam logic [TYPE_W-1:0] TYPE_TTAG = 5'd17;

    // Result kind codes
    localparam logic [KIND_W-1:0] KIND_DATA    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GHDR    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 3'd2;
    localparam logic [KIND_W-1:0] KIND_THDR    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TTRL    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TERR    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_TTAG    = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd7;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_SLOT     = 3'd1;
    localparam logic [ERR_W-1:0] ERR_STALE    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_SHORT    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TDC      = 3'd4;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN  = 3'd5;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SUM
    } t_state;

    // One channel entry of the hit store
    typedef struct packed {
        logic [CNT_W-1:0]   lead_cnt;
        logic [CNT_W-1:0]   trail_cnt;
        logic [VALUE_W-1:0] lead_time;
        logic [VALUE_W-1:0] trail_time;
    } t_entry;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ERR_W-1:0]   error;
        logic [SLOT_W-1:0]  slot;
        logic [CH_W-1:0]    channel;
        logic               edge_res;
        logic [CNT_W-1:0]   hit_index;
        logic [VALUE_W-1:0] lead_value;
        logic [VALUE_W-1:0] trail_value;
        logic [CNT_W-1:0]   lead_count;
        logic [CNT_W-1:0]   trail_count;
        logic [TAG_W-1:0]   trigger_time;
        logic               last;
    } t_result;

    // Map word type to result kind
    function automatic logic [KIND_W-1:0] kind_of(input logic [TYPE_W-1:0] typ);
        logic [KIND_W-1:0] k;
        case (typ)
            TYPE_DATA: k = KIND_DATA;
            TYPE_GHDR: k = KIND_GHDR;
            TYPE_GTRL: k = KIND_SUMMARY;
            TYPE_THDR: k = KIND_THDR;
            TYPE_TTRL: k = KIND_TTRL;
            TYPE_TERR: k = KIND_TERR;
            TYPE_TTAG: k = KIND_TTAG;
            default:   k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Saturating hit count increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

@@ sv/tdcu_ram.sv @@
// tdcu_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module tdcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/tdc_event_word_unpacker.sv @@
// tdc_event_word_unpacker: multi-hit TDC readout word decoder, top level.
// A word is accepted while its channel store entry is read; its result is registered
// and the entry written (modify/write) once the output is free, before the next word.
// A global trailer walks the store, one summary per cycle unless stalled, 32 in all.
// Reset (synchronous, active low) clears control, slot, time tag and the
// per-channel valid bits; the hit store RAM needs no clearing pass.
// Depends on tdcu_pkg and tdcu_ram.

module tdc_event_word_unpacker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [tdcu_pkg::SLOT_W-1:0]   i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tdcu_pkg::WORD_W-1:0]   i_word,
    input  logic                          i_first_word,
    input  logic                          i_last_word,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tdcu_pkg::KIND_W-1:0]   o_kind,
    output logic [tdcu_pkg::ERR_W-1:0]    o_error,
    output logic [tdcu_pkg::SLOT_W-1:0]   o_slot,
    output logic [tdcu_pkg::CH_W-1:0]     o_channel,
    output logic                          o_edge_res,
    output logic [tdcu_pkg::CNT_W-1:0]    o_hit_index,
    output logic [tdcu_pkg::VALUE_W-1:0]  o_lead_value,
    output logic [tdcu_pkg::VALUE_W-1:0]  o_trail_value,
    output logic [tdcu_pkg::CNT_W-1:0]    o_lead_count,
    output logic [tdcu_pkg::CNT_W-1:0]    o_trail_count,
    output logic [tdcu_pkg::TAG_W-1:0]    o_trigger_time,
    output logic                          o_last
);

    localparam int EW = $bits(tdcu_pkg::t_entry);
    localparam logic [tdcu_pkg::CH_W-1:0] CH_LAST = tdcu_pkg::CH_W'(tdcu_pkg::NUM_CHANNELS - 1);

    // Control and held state
    tdcu_pkg::t_state                    r_state, n_state;
    logic [tdcu_pkg::SLOT_W-1:0]         r_expected_slot;
    logic [tdcu_pkg::SLOT_W-1:0]         r_slot, n_slot;
    logic [tdcu_pkg::TAG_W-1:0]          r_tag, n_tag;
    logic                                r_trailer_seen;
    logic [tdcu_pkg::NUM_CHANNELS-1:0]   r_valid;
    logic [tdcu_pkg::CH_W-1:0]           r_ch;

    // Accepted word
    logic [tdcu_pkg::WORD_W-1:0]         r_word;
    logic                                r_short;
    logic                                r_stale;

    // Output register
    logic                                r_out_valid;
    tdcu_pkg::t_result                   r_out, n_out;

    // Store access
    logic                                ram_we, ram_re;
    logic [tdcu_pkg::CH_W-1:0]           ram_raddr;
    tdcu_pkg::t_entry                    ram_wdata, ram_rdata;
    logic [EW-1:0]                       ram_rdata_raw;

    logic                                accept, out_free, emit, stale_in;
    logic [tdcu_pkg::TYPE_W-1:0]         in_type, w_type;
    logic [tdcu_pkg::CH_W-1:0]           w_ch;
    logic                                w_edge;
    logic [tdcu_pkg::VALUE_W-1:0]        w_val;
    logic [tdcu_pkg::ERR_W-1:0]          base_err;
    logic [tdcu_pkg::CNT_W-1:0]          lc, tc;

    tdcu_ram #(
        .WIDTH (EW),
        .DEPTH (tdcu_pkg::NUM_CHANNELS)
    ) u_hit_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (w_ch),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = tdcu_pkg::t_entry'(ram_rdata_raw);

    // Handshake terms
    assign out_free = !r_out_valid || i_out_ready;
    assign accept   = i_in_valid && o_in_ready;
    assign in_type  = i_word[31:27];
    assign stale_in = r_trailer_seen && !i_first_word;

    // Decoded fields of the held word
    assign w_type   = r_word[31:27];
    assign w_edge   = r_word[26];
    assign w_ch     = r_word[25:21];
    assign w_val    = r_word[20:0];
    assign base_err = r_short ? tdcu_pkg::ERR_SHORT : tdcu_pkg::ERR_NONE;

    // Counts of the entry just read; invalid entries read as zero counts
    always_comb begin
        if (r_state == tdcu_pkg::S_SUM) begin
            lc = r_valid[r_ch] ? ram_rdata.lead_cnt  : '0;
            tc = r_valid[r_ch] ? ram_rdata.trail_cnt : '0;
        end else begin
            lc = r_valid[w_ch] ? ram_rdata.lead_cnt  : '0;
            tc = r_valid[w_ch] ? ram_rdata.trail_cnt : '0;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tdcu_pkg::S_IDLE: begin
                if (accept) begin
                    if (!stale_in && in_type == tdcu_pkg::TYPE_GTRL) begin
                        n_state = tdcu_pkg::S_SUM;
                    end else begin
                        n_state = tdcu_pkg::S_EXEC;
                    end
                end
            end
            tdcu_pkg::S_EXEC: begin
                if (out_free) begin
                    n_state = tdcu_pkg::S_IDLE;
                end
            end
            tdcu_pkg::S_SUM: begin
                if (out_free && r_ch == CH_LAST) begin
                    n_state = tdcu_pkg::S_IDLE;
                end
            end
            default: n_state = tdcu_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: ready, store read, emit
    always_comb begin
        o_in_ready = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        emit       = 1'b0;
        case (r_state)
            tdcu_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                ram_re     = accept;
                ram_raddr  = (in_type == tdcu_pkg::TYPE_GTRL) ? '0 : i_word[25:21];
            end
            tdcu_pkg::S_EXEC: begin
                emit = out_free;
            end
            tdcu_pkg::S_SUM: begin
                emit      = out_free;
                ram_re    = out_free && (r_ch != CH_LAST);
                ram_raddr = r_ch + 1'b1;
            end
            default: ;
        endcase
    end

    // Result and write-back data
    always_comb begin
        n_out              = '0;
        n_out.kind         = tdcu_pkg::kind_of(w_type);
        n_out.error        = base_err;
        n_out.last         = 1'b1;
        n_slot             = r_slot;
        n_tag              = r_tag;
        ram_we             = 1'b0;
        ram_wdata          = ram_rdata;
        ram_wdata.lead_cnt = lc;
        ram_wdata.trail_cnt = tc;

        if (r_state == tdcu_pkg::S_SUM) begin
            // channel summary
            n_out.kind        = tdcu_pkg::KIND_SUMMARY;
            n_out.channel     = r_ch;
            n_out.lead_count  = lc;
            n_out.trail_count = tc;
            n_out.lead_value  = (lc != '0) ? ram_rdata.lead_time  : '0;
            n_out.trail_value = (tc != '0) ? ram_rdata.trail_time : '0;
            n_out.last        = (r_ch == CH_LAST);
        end else if (r_stale) begin
            n_out.error = tdcu_pkg::ERR_STALE;
        end else begin
            case (n_out.kind)
                tdcu_pkg::KIND_DATA: begin
                    n_out.channel  = w_ch;
                    n_out.edge_res = w_edge;
                    ram_we         = emit;
                    if (!w_edge) begin
                        n_out.hit_index    = lc;
                        n_out.lead_value   = w_val;
                        ram_wdata.lead_cnt = tdcu_pkg::sat_inc(lc);
                        if (lc == '0) begin
                            ram_wdata.lead_time = w_val;
                        end
                    end else begin
                        n_out.hit_index     = tc;
                        n_out.trail_value   = w_val;
                        ram_wdata.trail_cnt = tdcu_pkg::sat_inc(tc);
                        if (tc == '0) begin
                            ram_wdata.trail_time = w_val;
                        end
                    end
                end
                tdcu_pkg::KIND_GHDR: begin
                    n_slot = r_word[4:0];
                    if (r_expected_slot != '0 && r_expected_slot != n_slot) begin
                        n_out.error = tdcu_pkg::ERR_SLOT;
                    end
                end
                tdcu_pkg::KIND_TERR:    n_out.error = tdcu_pkg::ERR_TDC;
                tdcu_pkg::KIND_TTAG:    n_tag = r_word[26:0];
                tdcu_pkg::KIND_UNKNOWN: n_out.error = tdcu_pkg::ERR_UNKNOWN;
                default: ;
            endcase
        end
        n_out.slot         = n_slot;
        n_out.trigger_time = n_tag;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= tdcu_pkg::S_IDLE;
            r_expected_slot <= '0;
            r_slot          <= '0;
            r_tag           <= '0;
            r_trailer_seen  <= 1'b0;
            r_valid         <= '0;
            r_ch            <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_expected_slot <= i_cfg_data;
            end
            // start of event clears counts, slot and trailer flag
            if (accept && i_first_word) begin
                r_valid        <= '0;
                r_slot         <= '0;
                r_trailer_seen <= 1'b0;
            end
            if (accept) begin
                r_ch <= '0;
            end
            if (emit) begin
                if (r_state == tdcu_pkg::S_EXEC) begin
                    r_slot <= n_slot;
                    r_tag  <= n_tag;
                    if (ram_we) begin
                        r_valid[w_ch] <= 1'b1;
                    end
                end else begin
                    r_ch <= r_ch + 1'b1;
                    if (r_ch == CH_LAST) begin
                        r_trailer_seen <= 1'b1;
                    end
                end
            end
            // output register
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word  <= i_word;
            r_short <= i_first_word && i_last_word;
            r_stale <= stale_in;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_error        = r_out.error;
    assign o_slot         = r_out.slot;
    assign o_channel      = r_out.channel;
    assign o_edge_res     = r_out.edge_res;
    assign o_hit_index    = r_out.hit_index;
    assign o_lead_value   = r_out.lead_value;
    assign o_trail_value  = r_out.trail_value;
    assign o_lead_count   = r_out.lead_count;
    assign o_trail_count  = r_out.trail_count;
    assign o_trigger_time = r_out.trigger_time;
    assign o_last         = r_out.last;

endmodule
